### src/gts_pkg.sv
// ----------------------------------------------------------------------------
// gts_pkg
// Shared types and constants for the three-species stochastic step unit.
// ----------------------------------------------------------------------------
package gts_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int SPONT_Q16_DEF   = 65536;

  localparam int FIELD_W   = 16;
  localparam int RATE_W    = 32;
  localparam int UNI_W     = 32;
  localparam int WGT_W     = 64;
  localparam int PROD_W    = 2 * WGT_W;
  localparam int DWELL_W   = 48;
  localparam int CH_W      = 3;
  localparam int NUM_CH    = 8;
  localparam int CFG_IDX_W = 4;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 104;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [CH_W-1:0] CH_PUMP   = 3'd0;
  localparam logic [CH_W-1:0] CH_LOSS_A = 3'd1;
  localparam logic [CH_W-1:0] CH_AB     = 3'd2;
  localparam logic [CH_W-1:0] CH_AC     = 3'd3;
  localparam logic [CH_W-1:0] CH_DEC_B  = 3'd4;
  localparam logic [CH_W-1:0] CH_DEC_C  = 3'd5;
  localparam logic [CH_W-1:0] CH_BC     = 3'd6;
  localparam logic [CH_W-1:0] CH_CB     = 3'd7;

  typedef enum logic [3:0] {
    STEP_P1, STEP_AB, STEP_P2, STEP_AC, STEP_P3, STEP_P4,
    STEP_P5, STEP_T6, STEP_P6, STEP_T7, STEP_P7, STEP_TGT
  } step_t;

  typedef enum logic [1:0] {DIR_NONE, DIR_INC, DIR_DEC} dir_t;

  typedef struct packed {
    logic  start_step;
    logic  load;
    logic  mul_start;
    logic  mul_post;
    logic  div_start;
    logic  finish;
    step_t step;
  } gts_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic out_free;
  } gts_sts_t;

endpackage

### src/gts_mul.sv
// ----------------------------------------------------------------------------
// gts_mul
// 64x64 unsigned multiplier built from one 32x32 unit, four partial products.
// ----------------------------------------------------------------------------
module gts_mul (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [gts_pkg::WGT_W-1:0] x,
  input  logic [gts_pkg::WGT_W-1:0] y,
  output logic                      done,
  output logic [gts_pkg::PROD_W-1:0] prod
);
  import gts_pkg::*;

  localparam int HALF = WGT_W / 2;

  logic [WGT_W-1:0]  x_r, y_r;
  logic [2:0]        idx_r;
  logic              busy_r, pp_v_r, done_r;
  logic [WGT_W-1:0]  pp_r;
  logic [1:0]        pp_sh_r;
  logic [PROD_W-1:0] acc_r;
  logic [HALF-1:0]   xa, ya;
  logic [1:0]        sh;
  logic [PROD_W-1:0] pp_ext;

  always_comb begin
    unique case (idx_r[1:0])
      2'd0: begin xa = x_r[HALF-1:0];     ya = y_r[HALF-1:0];     sh = 2'd0; end
      2'd1: begin xa = x_r[HALF-1:0];     ya = y_r[WGT_W-1:HALF]; sh = 2'd1; end
      2'd2: begin xa = x_r[WGT_W-1:HALF]; ya = y_r[HALF-1:0];     sh = 2'd1; end
      default: begin xa = x_r[WGT_W-1:HALF]; ya = y_r[WGT_W-1:HALF]; sh = 2'd2; end
    endcase
    pp_ext = PROD_W'(pp_r) << (HALF * int'(pp_sh_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pp_v_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        x_r    <= x;
        y_r    <= y;
        acc_r  <= '0;
        idx_r  <= '0;
        busy_r <= 1'b1;
        pp_v_r <= 1'b0;
      end else if (busy_r) begin
        if (idx_r != 3'd4) begin
          pp_r    <= WGT_W'(xa) * WGT_W'(ya);
          pp_sh_r <= sh;
          pp_v_r  <= 1'b1;
          idx_r   <= idx_r + 3'd1;
        end else begin
          pp_v_r <= 1'b0;
        end
        if (pp_v_r) acc_r <= acc_r + pp_ext;
        if (idx_r == 3'd4 && pp_v_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

### src/gts_div.sv
// ----------------------------------------------------------------------------
// gts_div
// Restoring divider forming 2^48 / divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gts_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [gts_pkg::WGT_W-1:0]   divisor,
  output logic                        done,
  output logic [gts_pkg::DWELL_W-1:0] quot
);
  import gts_pkg::*;

  logic [WGT_W-1:0]   d_r, rem_r;
  logic [DWELL_W:0]   q_r;
  logic [5:0]         cnt_r;
  logic               busy_r, done_r;
  logic [WGT_W:0]     trial;
  logic               ge;

  always_comb begin
    trial = {rem_r, (cnt_r == 6'(DWELL_W))};
    ge    = trial >= {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        d_r    <= divisor;
        rem_r  <= '0;
        q_r    <= '0;
        cnt_r  <= 6'(DWELL_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? WGT_W'(trial - {1'b0, d_r}) : trial[WGT_W-1:0];
        q_r   <= {q_r[DWELL_W-1:0], ge};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 6'd1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r[DWELL_W-1:0];

endmodule

### src/gts_dp.sv
// ----------------------------------------------------------------------------
// gts_dp
// Datapath: rates, counts, cumulative weights, shared multiplier and divider.
// ----------------------------------------------------------------------------
module gts_dp #(
  parameter int COUNT_WIDTH = gts_pkg::COUNT_WIDTH_DEF,
  parameter int SPONT_Q16   = gts_pkg::SPONT_Q16_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gts_pkg::gts_cmd_t             cmd,
  output gts_pkg::gts_sts_t             sts,
  input  logic                          cfg_wr,
  input  logic [gts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gts_pkg::RATE_W-1:0]    cfg_data,
  input  logic [gts_pkg::FIELD_W-1:0]   load_a,
  input  logic [gts_pkg::FIELD_W-1:0]   load_b,
  input  logic [gts_pkg::FIELD_W-1:0]   load_c,
  input  logic [gts_pkg::UNI_W-1:0]     uniform,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [gts_pkg::FIELD_W-1:0]   count_a,
  output logic [gts_pkg::FIELD_W-1:0]   count_b,
  output logic [gts_pkg::FIELD_W-1:0]   count_c,
  output logic [gts_pkg::DWELL_W-1:0]   dwell_time,
  output logic [gts_pkg::CH_W-1:0]      channel,
  output logic                          overflow
);
  import gts_pkg::*;

  localparam logic [WGT_W-1:0] WMAX = '1;

  logic [COUNT_WIDTH-1:0] cnt_r [3];
  logic [RATE_W-1:0]      rate_r [NUM_CH];
  logic [WGT_W-1:0]       w_r [NUM_CH];
  logic [WGT_W-1:0]       tmp_r, tgt_r;
  logic [UNI_W-1:0]       uni_r;
  logic                   sat_r;
  logic [DWELL_W-1:0]     dwell_r;
  logic                   out_valid_r;
  logic [FIELD_W-1:0]     oa_r, ob_r, oc_r;
  logic [DWELL_W-1:0]     odw_r;
  logic [CH_W-1:0]        och_r;
  logic                   oovf_r;

  logic [WGT_W-1:0]  a64, b64, c64, mx, my, mres, addres, wprev;
  logic              movf, addc, is_w, is_tmp;
  logic [CH_W-1:0]   dst;
  logic [WGT_W:0]    sum;
  logic              mul_done, div_done;
  logic [PROD_W-1:0] prod;
  logic [DWELL_W-1:0] quot;
  logic [CH_W-1:0]   ch;
  dir_t              da, db, dc;
  logic [COUNT_WIDTH:0] na, nb, nc;

  function automatic logic [FIELD_W-1:0] to_field(input logic [COUNT_WIDTH-1:0] v);
    logic [COUNT_WIDTH+FIELD_W-1:0] e;
    e = {{FIELD_W{1'b0}}, v};
    return e[FIELD_W-1:0];
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] from_field(input logic [FIELD_W-1:0] v);
    logic [COUNT_WIDTH+FIELD_W-1:0] e;
    e = {{COUNT_WIDTH{1'b0}}, v};
    return e[COUNT_WIDTH-1:0];
  endfunction

  function automatic logic [COUNT_WIDTH:0] bump(input logic [COUNT_WIDTH-1:0] v,
                                                input dir_t d);
    logic [COUNT_WIDTH:0] r;
    r = {1'b0, v};
    unique case (d)
      DIR_INC: r = (&v) ? {1'b1, v} : {1'b0, v + COUNT_WIDTH'(1)};
      DIR_DEC: r = (v == '0) ? {1'b1, v} : {1'b0, v - COUNT_WIDTH'(1)};
      default: r = {1'b0, v};
    endcase
    return r;
  endfunction

  assign a64 = WGT_W'(cnt_r[0]);
  assign b64 = WGT_W'(cnt_r[1]);
  assign c64 = WGT_W'(cnt_r[2]);

  always_comb begin
    mx = '0; my = '0; dst = '0; is_w = 1'b0; is_tmp = 1'b0;
    unique case (cmd.step)
      STEP_P1:  begin mx = WGT_W'(rate_r[1]); my = a64; dst = 3'd1; is_w = 1'b1; end
      STEP_AB:  begin mx = a64; my = b64 + WGT_W'(1); is_tmp = 1'b1; end
      STEP_P2:  begin mx = WGT_W'(rate_r[2]); my = tmp_r; dst = 3'd2; is_w = 1'b1; end
      STEP_AC:  begin mx = a64; my = c64 + WGT_W'(1); is_tmp = 1'b1; end
      STEP_P3:  begin mx = WGT_W'(rate_r[3]); my = tmp_r; dst = 3'd3; is_w = 1'b1; end
      STEP_P4:  begin mx = WGT_W'(rate_r[4]); my = b64; dst = 3'd4; is_w = 1'b1; end
      STEP_P5:  begin mx = WGT_W'(rate_r[5]); my = c64; dst = 3'd5; is_w = 1'b1; end
      STEP_T6:  begin mx = WGT_W'(rate_r[6]); my = b64; is_tmp = 1'b1; end
      STEP_P6:  begin
        mx = tmp_r; my = (c64 << 16) + WGT_W'(SPONT_Q16); dst = 3'd6; is_w = 1'b1;
      end
      STEP_T7:  begin mx = WGT_W'(rate_r[7]); my = c64; is_tmp = 1'b1; end
      STEP_P7:  begin
        mx = tmp_r; my = (b64 << 16) + WGT_W'(SPONT_Q16); dst = 3'd7; is_w = 1'b1;
      end
      STEP_TGT: begin mx = WGT_W'(uni_r); my = w_r[NUM_CH-1]; end
      default:  begin mx = '0; my = '0; end
    endcase
  end

  always_comb begin
    unique case (cmd.step)
      STEP_P6, STEP_P7: begin
        movf = |prod[PROD_W-1:80];
        mres = movf ? WMAX : prod[79:16];
      end
      STEP_TGT: begin
        movf = |prod[PROD_W-1:96];
        mres = movf ? WMAX : prod[95:32];
      end
      default: begin
        movf = |prod[PROD_W-1:WGT_W];
        mres = movf ? WMAX : prod[WGT_W-1:0];
      end
    endcase
    wprev  = w_r[dst - 3'd1];
    sum    = {1'b0, mres} + {1'b0, wprev};
    addc   = sum[WGT_W];
    addres = addc ? WMAX : sum[WGT_W-1:0];
  end

  always_comb begin
    ch = CH_CB;
    for (int k = NUM_CH - 1; k >= 0; k--) begin
      if (tgt_r < w_r[k]) ch = CH_W'(k);
    end
    da = DIR_NONE; db = DIR_NONE; dc = DIR_NONE;
    unique case (ch)
      CH_PUMP:   da = DIR_INC;
      CH_LOSS_A: da = DIR_DEC;
      CH_AB:     begin da = DIR_DEC; db = DIR_INC; end
      CH_AC:     begin da = DIR_DEC; dc = DIR_INC; end
      CH_DEC_B:  db = DIR_DEC;
      CH_DEC_C:  dc = DIR_DEC;
      CH_BC:     begin db = DIR_DEC; dc = DIR_INC; end
      default:   begin db = DIR_INC; dc = DIR_DEC; end
    endcase
    na = bump(cnt_r[0], da);
    nb = bump(cnt_r[1], db);
    nc = bump(cnt_r[2], dc);
  end

  gts_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .x     (mx),
    .y     (my),
    .done  (mul_done),
    .prod  (prod)
  );

  gts_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .divisor (w_r[NUM_CH-1]),
    .done    (div_done),
    .quot    (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) cnt_r[i] <= '0;
      for (int i = 0; i < NUM_CH; i++) rate_r[i] <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr && cfg_index < CFG_IDX_W'(NUM_CH)) begin
        rate_r[cfg_index[CH_W-1:0]] <= cfg_data;
      end
      if (cmd.load) begin
        cnt_r[0] <= from_field(load_a);
        cnt_r[1] <= from_field(load_b);
        cnt_r[2] <= from_field(load_c);
      end
      if (cmd.finish) begin
        cnt_r[0]    <= na[COUNT_WIDTH-1:0];
        cnt_r[1]    <= nb[COUNT_WIDTH-1:0];
        cnt_r[2]    <= nc[COUNT_WIDTH-1:0];
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_step) begin
      w_r[0] <= WGT_W'(rate_r[0]);
      uni_r  <= uniform;
      sat_r  <= 1'b0;
    end
    if (cmd.mul_post) begin
      if (is_w) begin
        w_r[dst] <= addres;
        sat_r    <= sat_r | movf | addc;
      end else if (is_tmp) begin
        tmp_r <= mres;
        sat_r <= sat_r | movf;
      end else begin
        tgt_r <= mres;
        sat_r <= sat_r | movf;
      end
    end
    if (div_done) begin
      if (w_r[NUM_CH-1][WGT_W-1:1] == '0) begin
        dwell_r <= '1;
        sat_r   <= 1'b1;
      end else begin
        dwell_r <= quot;
      end
    end
    if (cmd.finish) begin
      oa_r   <= to_field(cnt_r[0]);
      ob_r   <= to_field(cnt_r[1]);
      oc_r   <= to_field(cnt_r[2]);
      odw_r  <= dwell_r;
      och_r  <= ch;
      oovf_r <= sat_r | na[COUNT_WIDTH] | nb[COUNT_WIDTH] | nc[COUNT_WIDTH];
    end
  end

  assign sts.mul_done = mul_done;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign count_a    = oa_r;
  assign count_b    = ob_r;
  assign count_c    = oc_r;
  assign dwell_time = odw_r;
  assign channel    = och_r;
  assign overflow   = oovf_r;

endmodule

### src/gts_ctrl.sv
// ----------------------------------------------------------------------------
// gts_ctrl
// Controller sequencing count loads, the products, the reciprocal and the result write.
// ----------------------------------------------------------------------------
module gts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_ready,
  input  gts_pkg::gts_sts_t sts,
  output gts_pkg::gts_cmd_t cmd
);
  import gts_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_MUL, S_DIV, S_FINISH} state_t;

  state_t state_r;
  step_t  step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= STEP_P1;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_op == OP_STEP) begin
            state_r <= S_ISSUE;
            step_r  <= STEP_P1;
          end
        end
        S_ISSUE: state_r <= S_MUL;
        S_MUL: begin
          if (sts.mul_done) begin
            if (step_r == STEP_TGT) begin
              state_r <= S_DIV;
            end else begin
              step_r  <= step_t'(step_r + 4'd1);
              state_r <= S_ISSUE;
            end
          end
        end
        S_DIV: if (sts.div_done) state_r <= S_FINISH;
        S_FINISH: if (sts.out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    in_ready       = (state_r == S_IDLE);
    cmd.start_step = in_ready && in_valid && in_op == OP_STEP;
    cmd.load       = in_ready && in_valid && in_op == OP_LOAD;
    cmd.mul_start  = (state_r == S_ISSUE);
    cmd.div_start  = (state_r == S_ISSUE) && step_r == STEP_TGT;
    cmd.mul_post   = (state_r == S_MUL) && sts.mul_done;
    cmd.finish     = (state_r == S_FINISH) && sts.out_free;
    cmd.step       = step_r;
  end

endmodule

### src/gillespie_three_species_step_unit.sv
// ----------------------------------------------------------------------------
// gillespie_three_species_step_unit
// One direct-method stochastic step over three species and eight channels.
// ----------------------------------------------------------------------------
// The input stream carries a kind bit in in_tuser: a load beat sets the three
// counts and yields no result, a step beat brings a uniform fraction and yields
// one result beat with the prior counts, the dwell time, the chosen channel and
// a saturation flag. Rates are written through the cfg channel, which is always
// ready. Twelve 64-bit products run on one shared 32x32 multiplier at four
// partial products each, and the reciprocal divider overlaps the last one.
// One step is in flight at a time; loads are taken back to back.
// A finished result waits in the output register while the next beat is
// accepted; a stalled receiver holds the following step in its last cycle.
// Reset clears counts, rates and all handshake state.
// ----------------------------------------------------------------------------
module gillespie_three_species_step_unit #(
  parameter int COUNT_WIDTH = gts_pkg::COUNT_WIDTH_DEF,
  parameter int SPONT_Q16   = gts_pkg::SPONT_Q16_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // load_a[15:0], load_b[31:16], load_c[47:32], uniform[79:48]
  input  logic [gts_pkg::IN_DATA_W-1:0]  in_tdata,
  // op[0]
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // count_a[15:0], count_b[31:16], count_c[47:32], dwell_time[95:48],
  // channel[98:96], overflow[99], zero[103:100]
  output logic [gts_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gts_pkg::RATE_W-1:0]     cfg_data
);
  import gts_pkg::*;

  gts_cmd_t cmd;
  gts_sts_t sts;
  logic [FIELD_W-1:0] ca, cb, cc;
  logic [DWELL_W-1:0] dw;
  logic [CH_W-1:0]    ch;
  logic               ovf;

  assign cfg_ready = 1'b1;

  gts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gts_dp #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .SPONT_Q16   (SPONT_Q16)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .load_a     (in_tdata[15:0]),
    .load_b     (in_tdata[31:16]),
    .load_c     (in_tdata[47:32]),
    .uniform    (in_tdata[79:48]),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .count_a    (ca),
    .count_b    (cb),
    .count_c    (cc),
    .dwell_time (dw),
    .channel    (ch),
    .overflow   (ovf)
  );

  assign out_tdata = {4'b0, ovf, ch, dw, cc, cb, ca};

endmodule

### src/gts_checker.sv
// ----------------------------------------------------------------------------
// gts_checker
// Port-level checks on the step unit's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module gts_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic in_tuser,
  input logic out_tvalid,
  input logic out_tready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("Result beat dropped while stalled.");

  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("Input taken while a step is in progress.");

  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser |=> in_tready)
    else $error("Load beat stalled the input.");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("Result appeared without a step in progress.");

endmodule

bind gillespie_three_species_step_unit gts_checker u_gts_checker (.*);

### test/gillespie_three_species_step_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gillespie_three_species_step_unit_tb
// Self-checking bench for the three-species direct-method step unit.
// ----------------------------------------------------------------------------
// A behavioral model of the step (saturating Q16.16 rates, Q48.16 weights,
// channel selection and count update) predicts every result beat from the
// accepted input beats. Directed tests cover zero and saturated totals, each
// channel on its own, count limits and ignored register indexes. Random runs
// then load counts and walk the chain with random rate settings, while both
// stream sides idle at random. A last test stalls the receiver for long.
// ----------------------------------------------------------------------------
module gillespie_three_species_step_unit_tb;
  import gts_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_PUMP     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOSS_A   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AB       = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AC       = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEC_B    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEC_C    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BC       = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CB       = 4'd7;
  localparam logic [CFG_IDX_W-1:0] REG_LAST     = 4'd15;
  localparam logic [63:0]          SPONT        = 64'd65536;
  localparam logic [DWELL_W-1:0]   DWELL_SAT    = '1;

  typedef struct {
    logic [15:0]        cnt_a;
    logic [15:0]        cnt_b;
    logic [15:0]        cnt_c;
    logic [DWELL_W-1:0] dwell;
    logic [CH_W-1:0]    chan;
    logic               ovf;
  } step_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [RATE_W-1:0]     cfg_data;

  logic [RATE_W-1:0] rate_q16 [NUM_CH];
  logic [15:0]       species [3];
  bit                sat_seen;
  step_result_t      pending_results [$];
  int                error_count;
  int                hold_cycles;
  bit                no_gaps;

  gillespie_three_species_step_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [63:0] mul_clamp(input logic [63:0] x, input logic [63:0] y);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    if (p[127:64] != 0) begin
      sat_seen = 1'b1;
      return '1;
    end
    return p[63:0];
  endfunction

  function automatic logic [63:0] mul_shift_clamp(input logic [63:0] x, input logic [63:0] y,
                                                  input int sh);
    logic [127:0] p;
    p = ({64'd0, x} * {64'd0, y}) >> sh;
    if (p[127:64] != 0) begin
      sat_seen = 1'b1;
      return '1;
    end
    return p[63:0];
  endfunction

  function automatic logic [63:0] add_clamp(input logic [63:0] x, input logic [63:0] y);
    logic [64:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s[64]) begin
      sat_seen = 1'b1;
      return '1;
    end
    return s[63:0];
  endfunction

  function automatic void nudge_count(input int idx, input bit up);
    if (up) begin
      if (species[idx] == 16'hFFFF) sat_seen = 1'b1;
      else species[idx] = species[idx] + 16'd1;
    end else begin
      if (species[idx] == 16'd0) sat_seen = 1'b1;
      else species[idx] = species[idx] - 16'd1;
    end
  endfunction

  function automatic step_result_t gillespie_step(input logic [UNI_W-1:0] uniform);
    step_result_t r;
    logic [63:0]  a, b, c, total, target;
    logic [63:0]  w [NUM_CH];
    logic [CH_W-1:0] ch;
    sat_seen = 1'b0;
    a = {48'd0, species[0]};
    b = {48'd0, species[1]};
    c = {48'd0, species[2]};
    w[0] = {32'd0, rate_q16[0]};
    w[1] = add_clamp(mul_clamp({32'd0, rate_q16[1]}, a), w[0]);
    w[2] = add_clamp(mul_clamp({32'd0, rate_q16[2]}, mul_clamp(a, b + 1)), w[1]);
    w[3] = add_clamp(mul_clamp({32'd0, rate_q16[3]}, mul_clamp(a, c + 1)), w[2]);
    w[4] = add_clamp(mul_clamp({32'd0, rate_q16[4]}, b), w[3]);
    w[5] = add_clamp(mul_clamp({32'd0, rate_q16[5]}, c), w[4]);
    w[6] = add_clamp(mul_shift_clamp(mul_clamp({32'd0, rate_q16[6]}, b),
                                     (c << 16) + SPONT, 16), w[5]);
    w[7] = add_clamp(mul_shift_clamp(mul_clamp({32'd0, rate_q16[7]}, c),
                                     (b << 16) + SPONT, 16), w[6]);
    total = w[7];
    if (total <= 64'd1) begin
      r.dwell = DWELL_SAT;
      sat_seen = 1'b1;
    end else begin
      r.dwell = DWELL_W'((64'd1 << 48) / total);
    end
    target = mul_shift_clamp({32'd0, uniform}, total, 32);
    ch = CH_CB;
    for (int k = NUM_CH - 1; k >= 0; k--)
      if (target < w[k]) ch = CH_W'(k);
    r.cnt_a = species[0];
    r.cnt_b = species[1];
    r.cnt_c = species[2];
    r.chan  = ch;
    case (ch)
      CH_PUMP:   nudge_count(0, 1'b1);
      CH_LOSS_A: nudge_count(0, 1'b0);
      CH_AB: begin
        nudge_count(0, 1'b0);
        nudge_count(1, 1'b1);
      end
      CH_AC: begin
        nudge_count(0, 1'b0);
        nudge_count(2, 1'b1);
      end
      CH_DEC_B:  nudge_count(1, 1'b0);
      CH_DEC_C:  nudge_count(2, 1'b0);
      CH_BC: begin
        nudge_count(1, 1'b0);
        nudge_count(2, 1'b1);
      end
      default: begin
        nudge_count(1, 1'b1);
        nudge_count(2, 1'b0);
      end
    endcase
    r.ovf = sat_seen;
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    step_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report("unexpected beat", out_tdata[63:0], 64'd0);
      end else begin
        e = pending_results.pop_front();
        if (out_tdata[15:0] != e.cnt_a) report("count_a", out_tdata[15:0], e.cnt_a);
        if (out_tdata[31:16] != e.cnt_b) report("count_b", out_tdata[31:16], e.cnt_b);
        if (out_tdata[47:32] != e.cnt_c) report("count_c", out_tdata[47:32], e.cnt_c);
        if (out_tdata[95:48] != e.dwell) report("dwell_time", out_tdata[95:48], e.dwell);
        if (out_tdata[98:96] != e.chan) report("channel", out_tdata[98:96], e.chan);
        if (out_tdata[99] != e.ovf) report("overflow", out_tdata[99], e.ovf);
      end
    end
  end

  // Receiver: random stalls per beat, plus a long hold-off on request.
  always @(posedge clk) begin
    int stall_left;
    if (!rst_n) begin
      stall_left = 0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (out_tvalid && out_tready && !no_gaps) stall_left = $urandom_range(0, 10);
    end
  end

  task automatic send_item(input logic op, input logic [15:0] la, input logic [15:0] lb,
                           input logic [15:0] lc, input logic [UNI_W-1:0] uniform);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {uniform, lc, lb, la};
    do @(posedge clk); while (!in_tready);
    if (op == OP_LOAD) begin
      species[0] = la;
      species[1] = lb;
      species[2] = lc;
    end else begin
      pending_results.push_back(gillespie_step(uniform));
    end
  endtask

  task automatic send_step(input logic [UNI_W-1:0] uniform);
    send_item(OP_STEP, 16'($urandom), 16'($urandom), 16'($urandom), uniform);
  endtask

  task automatic send_load(input logic [15:0] la, input logic [15:0] lb, input logic [15:0] lc);
    send_item(OP_LOAD, la, lb, lc, $urandom);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_rate(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx < NUM_CH) rate_q16[idx[CH_W-1:0]] = val;
  endtask

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      3:       return $urandom_range(0, 32'h0004_0000);
      default: return $urandom_range(0, 32'h0000_4000);
    endcase
  endfunction

  function automatic logic [15:0] pick_count();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(0, 40));
    endcase
  endfunction

  function automatic logic [UNI_W-1:0] pick_uniform();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_zero_total();
    send_step('0);
    send_step('1);
    send_load(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_step(32'h8000_0000);
    wait_idle();
  endtask

  task automatic test_single_channels();
    for (int k = 0; k < NUM_CH; k++) begin
      for (int j = 0; j < NUM_CH; j++) write_rate(CFG_IDX_W'(j), (j == k) ? 32'h0001_0000 : '0);
      send_load(16'd3, 16'd2, 16'd1);
      send_step(pick_uniform());
      send_load(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_step(32'h4000_0000);
      wait_idle();
    end
  endtask

  task automatic test_saturation();
    for (int j = 0; j < NUM_CH; j++) write_rate(CFG_IDX_W'(j), '1);
    send_load(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_step('1);
    send_step('0);
    send_load(16'd0, 16'd0, 16'd0);
    send_step('1);
    wait_idle();
    write_rate(REG_PUMP, 32'd1);
    for (int j = 1; j < NUM_CH; j++) write_rate(CFG_IDX_W'(j), '0);
    send_step(32'h1234_5678);
    wait_idle();
  endtask

  task automatic test_ignored_index();
    write_rate(4'd8, '1);
    write_rate(REG_LAST, '1);
    write_rate(4'($urandom_range(9, 14)), $urandom);
    send_load(16'd5, 16'd5, 16'd5);
    send_step(pick_uniform());
    wait_idle();
  endtask

  task automatic test_random_chains(input int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      if (sent % 120 == 0) begin
        wait_idle();
        no_gaps = ($urandom_range(0, 3) == 0);
        for (int j = 0; j < NUM_CH; j++) write_rate(CFG_IDX_W'(j), pick_rate());
      end
      if ($urandom_range(0, 9) == 0) begin
        send_item(1'($urandom_range(0, 1)), pick_count(), pick_count(), pick_count(),
                  $urandom);
        sent++;
      end else begin
        send_load(pick_count(), pick_count(), pick_count());
        sent++;
        repeat ($urandom_range(3, 25)) begin
          send_step(pick_uniform());
          sent++;
        end
      end
    end
    wait_idle();
    no_gaps = 1'b0;
  endtask

  task automatic test_backpressure();
    for (int j = 0; j < NUM_CH; j++) write_rate(CFG_IDX_W'(j), 32'h0000_8000);
    send_load(16'd20, 16'd20, 16'd20);
    hold_cycles = 800;
    repeat (6) send_step($urandom);
    send_load(16'd7, 16'd9, 16'd11);
    repeat (4) send_step($urandom);
    wait_idle();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tuser    = OP_LOAD;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    error_count = 0;
    hold_cycles = 0;
    no_gaps     = 1'b0;
    for (int j = 0; j < NUM_CH; j++) rate_q16[j] = '0;
    for (int j = 0; j < 3; j++) species[j] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_total();
    test_single_channels();
    test_saturation();
    test_ignored_index();
    test_random_chains(880);
    test_backpressure();

    wait_idle();
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
